>>> hw/rtl/scd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Types and constants shared by the SPI command decoder modules.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam logic [7:0] REPLY_OK   = 8'h80;
  localparam logic [7:0] REPLY_MORE = 8'hA0;
  localparam logic [7:0] REPLY_ERR  = 8'hFF;

  localparam int OFF_W = 11;
  localparam logic [OFF_W-1:0] OFFSET_MAX = 11'd2047;

  localparam int RX_DEPTH  = 16;
  localparam int RX_AW     = 4;
  localparam int IDX_W     = 5;
  localparam int UID_BYTES = 8;
  localparam int SIG_BYTES = 4;
  localparam int FILT_ROW  = 3;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE = 1'b1;

  typedef enum logic [1:0] {
    EV_SEL_FALL = 2'd0,
    EV_BYTE     = 2'd1,
    EV_SEL_RISE = 2'd2,
    EV_RX_LOAD  = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    CMD_NULL        = 4'd0,
    CMD_UID         = 4'd1,
    CMD_SIG         = 4'd2,
    CMD_LED         = 4'd3,
    CMD_RESET       = 4'd4,
    CMD_STATUS_CLR  = 4'd5,
    CMD_STATUS      = 4'd6,
    CMD_TX_WRITE    = 4'd7,
    CMD_TX_COMMIT   = 4'd8,
    CMD_RX_READ     = 4'd9,
    CMD_RX_SHIFT    = 4'd10,
    CMD_FILT_WRITE  = 4'd11,
    CMD_FILT_COMMIT = 4'd12,
    CMD_FILT_READ   = 4'd13,
    CMD_NODE_FILT   = 4'd14
  } command_t;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_LED_OFF     = 4'd1,
    ACT_LED_ON      = 4'd2,
    ACT_CAN_RESTART = 4'd3,
    ACT_SYS_RESET   = 4'd4,
    ACT_ERR_CLEAR   = 4'd5,
    ACT_TX_WRITE    = 4'd6,
    ACT_TX_COMMIT   = 4'd7,
    ACT_RX_SHIFT    = 4'd8,
    ACT_FILT_WRITE  = 4'd9,
    ACT_FILT_COMMIT = 4'd10,
    ACT_NODE_FILT   = 4'd11
  } action_t;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_RX    = 2'd1,
    SRC_FILT  = 2'd2
  } reply_src_t;

  typedef struct packed {
    logic             reply_valid;
    reply_src_t       src;
    logic [7:0]       reply;
    action_t          action;
    logic [IDX_W-1:0] index;
    logic [7:0]       value;
  } item_t;

  typedef struct packed {
    logic             rx_en;
    logic             rx_we;
    logic [RX_AW-1:0] rx_addr;
    logic             fl_en;
    logic             fl_we;
    logic [IDX_W-1:0] fl_addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/scd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_decode
// Frame state, configuration registers and per-byte command decode.
// ----------------------------------------------------------------------------
module scd_decode #(
  parameter int BUF_LEN      = 16,
  parameter int FILTER_COUNT = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scd_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           accept,
  input  wire scd_pkg::event_t                ev,
  input  wire logic [7:0]                     data_byte,
  input  wire logic [scd_pkg::RX_AW-1:0]      load_index,
  input  wire logic [7:0]                     status_now,
  output scd_pkg::item_t                      item,
  output scd_pkg::mem_req_t                   req
);

  localparam int FILT_BYTES = scd_pkg::FILT_ROW * FILTER_COUNT;
  localparam logic [scd_pkg::OFF_W-1:0] BUF_END = scd_pkg::OFF_W'(BUF_LEN);
  localparam logic [scd_pkg::OFF_W-1:0] FW_END  = scd_pkg::OFF_W'(FILT_BYTES + 3);
  localparam logic [scd_pkg::OFF_W-1:0] FR_END  = scd_pkg::OFF_W'(FILT_BYTES + 2);
  localparam logic [scd_pkg::OFF_W-1:0] RX_END  = scd_pkg::OFF_W'(scd_pkg::RX_DEPTH);
  localparam logic [scd_pkg::OFF_W-1:0] UID_END = scd_pkg::OFF_W'(scd_pkg::UID_BYTES);
  localparam logic [scd_pkg::OFF_W-1:0] SIG_END = scd_pkg::OFF_W'(scd_pkg::SIG_BYTES);

  logic [63:0]                 unique_id;
  logic [31:0]                 signature;
  logic                        in_frame;
  logic                        awaiting;
  logic [7:0]                  opcode;
  logic [scd_pkg::OFF_W-1:0]   offset;
  logic [scd_pkg::OFF_W-1:0]   offset_next;

  logic                        first;
  logic [7:0]                  opc;
  logic [scd_pkg::OFF_W-1:0]   off;
  logic [scd_pkg::OFF_W-1:0]   off_inc;
  logic [scd_pkg::OFF_W-1:0]   jump;
  logic [scd_pkg::OFF_W-1:0]   tx_idx;
  logic [scd_pkg::OFF_W-1:0]   rd_idx;
  logic [scd_pkg::OFF_W-1:0]   wr_idx;
  scd_pkg::command_t           cmd;

  assign first   = awaiting;
  assign off_inc = (offset == scd_pkg::OFFSET_MAX) ? offset : offset + 11'd1;
  assign opc     = first ? data_byte : opcode;
  assign off     = first ? '0 : off_inc;
  assign jump    = {3'b000, data_byte} + {2'b00, data_byte, 1'b0} + 11'd2;
  assign tx_idx  = off - 11'd1;
  assign rd_idx  = off - 11'd2;
  assign wr_idx  = off - 11'd3;
  assign cmd     = scd_pkg::command_t'(opc[3:0]);

  always_comb begin
    item.reply_valid = 1'b0;
    item.src         = scd_pkg::SRC_CONST;
    item.reply       = 8'h00;
    item.action      = scd_pkg::ACT_NONE;
    item.index       = '0;
    item.value       = 8'h00;
    req.rx_en        = 1'b0;
    req.rx_we        = 1'b0;
    req.rx_addr      = load_index;
    req.fl_en        = 1'b0;
    req.fl_we        = 1'b0;
    req.fl_addr      = '0;
    req.wdata        = data_byte;
    offset_next      = off;
    unique case (ev)
      scd_pkg::EV_RX_LOAD: begin
        req.rx_en = accept;
        req.rx_we = 1'b1;
      end
      scd_pkg::EV_BYTE: begin
        if (in_frame) begin
          item.reply_valid = 1'b1;
          item.reply       = scd_pkg::REPLY_ERR;
          if (opc[7:4] == 4'd0) begin
            unique case (cmd)
              scd_pkg::CMD_UID: begin
                if (off < UID_END) begin
                  item.reply = unique_id[{off[2:0], 3'b000} +: 8];
                end
              end
              scd_pkg::CMD_SIG: begin
                if (off < SIG_END) begin
                  item.reply = signature[{off[1:0], 3'b000} +: 8];
                end
              end
              scd_pkg::CMD_LED: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = (data_byte == 8'h00) ? scd_pkg::ACT_LED_OFF
                                                     : scd_pkg::ACT_LED_ON;
                end
              end
              scd_pkg::CMD_RESET: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1 && data_byte == 8'h00) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_CAN_RESTART;
                end else if (off == 11'd1 && data_byte == 8'h01) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_SYS_RESET;
                end
              end
              scd_pkg::CMD_STATUS_CLR: begin
                if (first) begin
                  item.reply  = status_now;
                  item.action = scd_pkg::ACT_ERR_CLEAR;
                end
              end
              scd_pkg::CMD_STATUS: begin
                item.reply = status_now;
              end
              scd_pkg::CMD_TX_WRITE: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off < BUF_END) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_TX_WRITE;
                  item.index  = tx_idx[scd_pkg::IDX_W-1:0];
                  item.value  = data_byte;
                end
              end
              scd_pkg::CMD_TX_COMMIT: begin
                if (first) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_TX_COMMIT;
                end
              end
              scd_pkg::CMD_RX_READ: begin
                if (off < BUF_END) begin
                  if (off < RX_END) begin
                    item.src    = scd_pkg::SRC_RX;
                    req.rx_en   = accept;
                    req.rx_addr = off[scd_pkg::RX_AW-1:0];
                  end else begin
                    item.reply = 8'h00;
                  end
                end
              end
              scd_pkg::CMD_RX_SHIFT: begin
                if (first) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_RX_SHIFT;
                end
              end
              scd_pkg::CMD_FILT_WRITE: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1) begin
                  item.reply  = scd_pkg::REPLY_MORE;
                  offset_next = jump;
                end else if (off >= 11'd3 && off < FW_END) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_FILT_WRITE;
                  item.index  = wr_idx[scd_pkg::IDX_W-1:0];
                  item.value  = data_byte;
                  req.fl_en   = accept;
                  req.fl_we   = 1'b1;
                  req.fl_addr = wr_idx[scd_pkg::IDX_W-1:0];
                end
              end
              scd_pkg::CMD_FILT_COMMIT: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_FILT_COMMIT;
                  item.value  = data_byte;
                end
              end
              scd_pkg::CMD_FILT_READ: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1) begin
                  item.reply  = scd_pkg::REPLY_MORE;
                  offset_next = jump;
                end else if (off >= 11'd2 && off < FR_END) begin
                  item.src    = scd_pkg::SRC_FILT;
                  req.fl_en   = accept;
                  req.fl_addr = rd_idx[scd_pkg::IDX_W-1:0];
                end
              end
              scd_pkg::CMD_NODE_FILT: begin
                if (first) begin
                  item.reply = scd_pkg::REPLY_MORE;
                end else if (off == 11'd1) begin
                  item.reply  = scd_pkg::REPLY_OK;
                  item.action = scd_pkg::ACT_NODE_FILT;
                  item.value  = data_byte;
                end else begin
                  item.reply_valid = 1'b0;
                  item.reply       = 8'h00;
                end
              end
              default: begin
                item.reply = scd_pkg::REPLY_ERR;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unique_id <= '0;
      signature <= '0;
      in_frame  <= 1'b0;
      awaiting  <= 1'b0;
      opcode    <= 8'h00;
      offset    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          scd_pkg::CFG_UNIQUE_ID: unique_id <= cfg_data;
          scd_pkg::CFG_SIGNATURE: signature <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        unique case (ev)
          scd_pkg::EV_SEL_FALL: begin
            in_frame <= 1'b1;
            awaiting <= 1'b1;
            offset   <= '0;
          end
          scd_pkg::EV_BYTE: begin
            if (in_frame) begin
              opcode   <= opc;
              awaiting <= 1'b0;
              offset   <= offset_next;
            end
          end
          scd_pkg::EV_SEL_RISE: begin
            in_frame <= 1'b0;
            awaiting <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scd_stores.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_stores
// Receive store and filter store memories, registered reads.
// ----------------------------------------------------------------------------
module scd_stores #(
  parameter int FILTER_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scd_pkg::mem_req_t req,
  output logic [7:0]             rx_q,
  output logic [7:0]             fl_q
);

  localparam int FILT_BYTES = scd_pkg::FILT_ROW * FILTER_COUNT;
  localparam int FAW        = $clog2(FILT_BYTES);

  logic [7:0]            rx_mem [scd_pkg::RX_DEPTH];
  logic [7:0]            fl_mem [FILT_BYTES];
  logic [FILT_BYTES-1:0] fl_vld;
  logic [7:0]            fl_data;
  logic                  fl_hit;
  logic [FAW-1:0]        fl_addr;

  assign fl_addr = req.fl_addr[FAW-1:0];
  assign fl_q    = fl_hit ? fl_data : 8'h00;

  always_ff @(posedge clk) begin
    if (req.rx_en) begin
      if (req.rx_we) begin
        rx_mem[req.rx_addr] <= req.wdata;
      end else begin
        rx_q <= rx_mem[req.rx_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fl_en) begin
      if (req.fl_we) begin
        fl_mem[fl_addr] <= req.wdata;
      end else begin
        fl_data <= fl_mem[fl_addr];
        fl_hit  <= fl_vld[fl_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_vld <= '0;
    end else if (req.fl_en && req.fl_we) begin
      fl_vld[fl_addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scd_reply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_reply
// Read-data stage, reply select and output register with flow control.
// ----------------------------------------------------------------------------
module scd_reply (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire scd_pkg::item_t item,
  input  wire logic [7:0]     rx_q,
  input  wire logic [7:0]     fl_q,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_user,
  output logic [31:0]         out_data
);

  scd_pkg::item_t s1;
  logic           s1_valid;
  logic           s1_adv;
  logic [7:0]     reply;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_comb begin
    case (s1.src)
      scd_pkg::SRC_RX:   reply = rx_q;
      scd_pkg::SRC_FILT: reply = fl_q;
      default:           reply = s1.reply;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_user <= s1.reply_valid;
      out_data <= {7'b0000000, s1.value, s1.index, s1.action, reply};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spi_command_slave_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_command_slave_decoder
// Byte-level command engine of an SPI slave in front of a CAN controller.
//
//   channel   dir  handshake               contents
//   s_axis    in   tvalid/tready           event, SPI byte, load index, status
//   m_axis    out  tvalid/tready           reply flag, reply, side action
//   cfg       in   cfg_we                  unique id, signature
//
// One transfer per cycle in each direction unless the output stalls. Stages:
// decode and memory read, then reply select into the output register.
// Reset clears frame state, registers and filter store valid bits.
// A stalled output holds the read stage; input ready drops only when both full.
// ----------------------------------------------------------------------------
module spi_command_slave_decoder #(
  parameter int BUF_LEN      = 16,
  parameter int FILTER_COUNT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,  // data_byte, load_index, status_now
  input  wire logic [1:0]                    s_axis_tuser,  // op
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // reply_byte, action, action_index,
                                                            // action_value
  output logic                               m_axis_tuser,  // reply_valid
  input  wire logic                          cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scd_pkg::CFG_W-1:0]     cfg_data
);

  logic              accept;
  scd_pkg::item_t    item;
  scd_pkg::mem_req_t req;
  logic [7:0]        rx_q;
  logic [7:0]        fl_q;

  assign accept = s_axis_tvalid && s_axis_tready;

  scd_decode #(
    .BUF_LEN      (BUF_LEN),
    .FILTER_COUNT (FILTER_COUNT)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .ev         (scd_pkg::event_t'(s_axis_tuser)),
    .data_byte  (s_axis_tdata[7:0]),
    .load_index (s_axis_tdata[11:8]),
    .status_now (s_axis_tdata[19:12]),
    .item       (item),
    .req        (req)
  );

  scd_stores #(
    .FILTER_COUNT (FILTER_COUNT)
  ) u_stores (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rx_q (rx_q),
    .fl_q (fl_q)
  );

  scd_reply u_reply (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .rx_q      (rx_q),
    .fl_q      (fl_q),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_user  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> hw/rtl/scd_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scd_chk
// Port-level checks for the SPI command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module scd_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic        m_axis_tuser,
  input wire logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'h0)
    else $error("transfer without reply carries nonzero data");

  a_index_use: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[11:8] != scd_pkg::ACT_TX_WRITE &&
      m_axis_tdata[11:8] != scd_pkg::ACT_FILT_WRITE |-> m_axis_tdata[16:12] == 5'd0)
    else $error("action index set for an action without one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output appeared without an input transfer two cycles before");

endmodule

bind spi_command_slave_decoder scd_chk u_scd_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_spi_command_slave_decoder.sv
// ----------------------------------------------------------------------------
// tb_spi_command_slave_decoder
// Self-checking testbench for the SPI command decoder. A behavioral decoder
// tracks frame state, unique id, signature, receive and filter stores and
// queues the reply expected for every accepted input transfer. Each output
// transfer is compared field by field with the oldest queued reply. Stimulus
// runs through directed command frames, frames at far offsets, a long
// output hold-off, then random frames under several register settings.
// ----------------------------------------------------------------------------
module tb_spi_command_slave_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_LEN         = 16;
  localparam int FILTER_COUNT    = 8;
  localparam int FILT_BYTES      = scd_pkg::FILT_ROW * FILTER_COUNT;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_ITEMS    = 480;
  localparam int FAR_FRAME_BYTES = 24;

  typedef struct {
    logic                      valid;
    logic [7:0]                reply;
    scd_pkg::action_t          act;
    logic [scd_pkg::IDX_W-1:0] idx;
    logic [7:0]                val;
  } reply_rec_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [23:0]                   s_axis_tdata = '0;  // data_byte, load_index, status_now
  logic [1:0]                    s_axis_tuser = '0;  // op
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;  // reply_byte, action, action_index, action_value
  logic                          m_axis_tuser;  // reply_valid
  logic                          cfg_we = 1'b0;
  logic [scd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scd_pkg::CFG_W-1:0]     cfg_data = '0;

  // decoder shadow state
  logic                      link_open = 1'b0;
  logic                      want_opcode = 1'b0;
  logic [7:0]                cmd_code = '0;
  logic [scd_pkg::OFF_W-1:0] cmd_offset = '0;
  logic [7:0]                rx_bytes [scd_pkg::RX_DEPTH];
  logic [7:0]                filt_bytes [FILT_BYTES];
  logic [63:0]               uid_reg = '0;
  logic [31:0]               sig_reg = '0;

  reply_rec_t expected_replies[$];

  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  bit          hold_off_req = 1'b0;
  logic        sink_held = 1'b0;
  int unsigned sink_stall_left = 0;

  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_frames = 0;
  int n_actions = 0;
  int n_filt_writes = 0;

  spi_command_slave_decoder #(
    .BUF_LEN      (BUF_LEN),
    .FILTER_COUNT (FILTER_COUNT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (filt_bytes[i]) filt_bytes[i] = 8'h00;
    foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic reply_rec_t predict_reply(scd_pkg::event_t ev, logic [7:0] b,
                                               logic [3:0] li, logic [7:0] st);
    reply_rec_t r;
    logic       first;
    int         off;
    r = '{valid: 1'b0, reply: 8'h00, act: scd_pkg::ACT_NONE, idx: '0, val: 8'h00};
    case (ev)
      scd_pkg::EV_SEL_FALL: begin
        link_open   = 1'b1;
        want_opcode = 1'b1;
        cmd_offset  = '0;
      end
      scd_pkg::EV_SEL_RISE: begin
        link_open   = 1'b0;
        want_opcode = 1'b0;
      end
      scd_pkg::EV_RX_LOAD: begin
        rx_bytes[li] = b;
      end
      default: begin
        if (link_open) begin
          first = want_opcode;
          if (first) begin
            cmd_code    = b;
            cmd_offset  = '0;
            want_opcode = 1'b0;
          end else if (cmd_offset < scd_pkg::OFFSET_MAX) begin
            cmd_offset = cmd_offset + 1'b1;
          end
          off = int'(cmd_offset);
          r.valid = 1'b1;
          r.reply = scd_pkg::REPLY_ERR;
          case (cmd_code)
            scd_pkg::CMD_UID:
              if (off < scd_pkg::UID_BYTES) r.reply = 8'(uid_reg >> (8 * off));
            scd_pkg::CMD_SIG:
              if (off < scd_pkg::SIG_BYTES) r.reply = 8'(sig_reg >> (8 * off));
            scd_pkg::CMD_LED: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = (b == 8'h00) ? scd_pkg::ACT_LED_OFF : scd_pkg::ACT_LED_ON;
              end
            end
            scd_pkg::CMD_RESET: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1 && b == 8'd0) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_CAN_RESTART;
              end else if (off == 1 && b == 8'd1) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_SYS_RESET;
              end
            end
            scd_pkg::CMD_STATUS_CLR: begin
              if (first) begin
                r.reply = st;
                r.act   = scd_pkg::ACT_ERR_CLEAR;
              end
            end
            scd_pkg::CMD_STATUS: r.reply = st;
            scd_pkg::CMD_TX_WRITE: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off < BUF_LEN) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_TX_WRITE;
                r.idx   = scd_pkg::IDX_W'(off - 1);
                r.val   = b;
              end
            end
            scd_pkg::CMD_TX_COMMIT: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_TX_COMMIT;
              end
            end
            scd_pkg::CMD_RX_READ: begin
              if (off < BUF_LEN)
                r.reply = (off < scd_pkg::RX_DEPTH) ? rx_bytes[off] : 8'h00;
            end
            scd_pkg::CMD_RX_SHIFT: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_RX_SHIFT;
              end
            end
            scd_pkg::CMD_FILT_WRITE: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1) begin
                cmd_offset = scd_pkg::OFF_W'(3 * int'(b) + 2);
                r.reply    = scd_pkg::REPLY_MORE;
              end else if (off >= 3 && off < FILT_BYTES + 3) begin
                filt_bytes[off - 3] = b;
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_FILT_WRITE;
                r.idx   = scd_pkg::IDX_W'(off - 3);
                r.val   = b;
                n_filt_writes++;
              end
            end
            scd_pkg::CMD_FILT_COMMIT: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_FILT_COMMIT;
                r.val   = b;
              end
            end
            scd_pkg::CMD_FILT_READ: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1) begin
                cmd_offset = scd_pkg::OFF_W'(3 * int'(b) + 2);
                r.reply    = scd_pkg::REPLY_MORE;
              end else if (off >= 2 && off < FILT_BYTES + 2) begin
                r.reply = filt_bytes[off - 2];
              end
            end
            scd_pkg::CMD_NODE_FILT: begin
              if (first) begin
                r.reply = scd_pkg::REPLY_MORE;
              end else if (off == 1) begin
                r.reply = scd_pkg::REPLY_OK;
                r.act   = scd_pkg::ACT_NODE_FILT;
                r.val   = b;
              end else begin
                r.valid = 1'b0;
                r.reply = 8'h00;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
    n_errors++;
    if (n_errors <= 40)
      $display("[%0t] reply %0d: %s got 0x%0h, want 0x%0h", $time, n_checked, what, got,
               want_v);
  endtask

  task automatic send_event(scd_pkg::event_t ev, logic [7:0] b, logic [3:0] li,
                            logic [7:0] st);
    reply_rec_t r;
    if (src_gaps_on && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev;
    s_axis_tdata  <= {4'h0, st, li, b};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_reply(ev, b, li, st);
    if (r.act != scd_pkg::ACT_NONE) n_actions++;
    expected_replies.push_back(r);
    n_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    logic [7:0] st;
    case ($urandom_range(0, 7))
      0:       st = 8'h00;
      1:       st = 8'hFF;
      default: st = 8'($urandom);
    endcase
    send_event(scd_pkg::EV_BYTE, b, 4'($urandom), st);
  endtask

  task automatic run_frame(logic [7:0] opc, logic [7:0] arg, int n_args);
    send_event(scd_pkg::EV_SEL_FALL, 8'($urandom), 4'($urandom), 8'($urandom));
    send_byte(opc);
    for (int i = 0; i < n_args; i++) send_byte(i == 0 ? arg : 8'($urandom));
    // leave the odd frame open; the next select fall re-arms it
    if ($urandom_range(0, 15) != 0)
      send_event(scd_pkg::EV_SEL_RISE, 8'($urandom), 4'($urandom), 8'($urandom));
    n_frames++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_ident(logic [63:0] uid, logic [31:0] sig);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= scd_pkg::CFG_UNIQUE_ID;
    cfg_data  <= uid;
    @(posedge clk);
    cfg_index <= scd_pkg::CFG_SIGNATURE;
    cfg_data  <= {32'($urandom), sig};
    @(posedge clk);
    cfg_we  <= 1'b0;
    uid_reg = uid;
    sig_reg = sig;
    @(posedge clk);
  endtask

  task automatic random_frame();
    logic [7:0] opc;
    logic [7:0] arg;
    int         pick;
    int         n_args;
    pick = $urandom_range(0, 99);
    if (pick < 90) opc = 8'($urandom_range(0, 14));
    else if (pick < 94) opc = 8'(scd_pkg::CMD_NULL) | 8'h0F;
    else opc = 8'($urandom_range(16, 255));
    arg = 8'($urandom);
    case (opc)
      scd_pkg::CMD_LED, scd_pkg::CMD_RESET:
        if ($urandom_range(0, 3) != 0) arg = 8'($urandom_range(0, 2));
      scd_pkg::CMD_FILT_WRITE, scd_pkg::CMD_FILT_READ:
        if ($urandom_range(0, 7) != 0) arg = 8'($urandom_range(0, FILTER_COUNT));
      default: ;
    endcase
    n_args = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_event(scd_pkg::EV_RX_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
    end else if (pick < 7) begin
      send_byte(8'($urandom));
    end else if (pick < 10) begin
      send_event(scd_pkg::EV_SEL_FALL, 8'($urandom), 4'($urandom), 8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 12) begin
      send_event(scd_pkg::EV_SEL_RISE, 8'($urandom), 4'($urandom), 8'($urandom));
    end
    run_frame(opc, arg, n_args);
  endtask

  // fill every receive entry so no read ever hits an unloaded one
  task automatic test_rx_load();
    for (int i = 0; i < scd_pkg::RX_DEPTH; i++)
      send_event(scd_pkg::EV_RX_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                 4'(i), 8'($urandom));
  endtask

  task automatic test_ident_registers();
    run_frame(scd_pkg::CMD_UID, 8'h00, scd_pkg::UID_BYTES);
    load_ident('1, '1);
    run_frame(scd_pkg::CMD_UID, 8'h00, scd_pkg::UID_BYTES);
    run_frame(scd_pkg::CMD_SIG, 8'h00, scd_pkg::SIG_BYTES);
    load_ident(64'h0123_4567_89AB_CDEF, 32'h5A3C_96E1);
    run_frame(scd_pkg::CMD_UID, 8'h00, scd_pkg::UID_BYTES);
    run_frame(scd_pkg::CMD_SIG, 8'h00, scd_pkg::SIG_BYTES);
  endtask

  task automatic test_commands();
    send_event(scd_pkg::EV_SEL_RISE, 8'h00, 4'h0, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    run_frame(scd_pkg::CMD_NULL, 8'h00, 1);
    run_frame(scd_pkg::CMD_LED, 8'h00, 1);
    run_frame(scd_pkg::CMD_LED, 8'hFF, 2);
    run_frame(scd_pkg::CMD_RESET, 8'd0, 1);
    run_frame(scd_pkg::CMD_RESET, 8'd1, 1);
    run_frame(scd_pkg::CMD_RESET, 8'd2, 2);
    run_frame(scd_pkg::CMD_STATUS_CLR, 8'h00, 1);
    run_frame(scd_pkg::CMD_STATUS, 8'h00, 3);
    run_frame(scd_pkg::CMD_TX_WRITE, 8'hA5, BUF_LEN);
    run_frame(scd_pkg::CMD_TX_COMMIT, 8'h00, 1);
    run_frame(scd_pkg::CMD_RX_READ, 8'h00, BUF_LEN);
    run_frame(scd_pkg::CMD_RX_SHIFT, 8'h00, 1);
    run_frame(scd_pkg::CMD_FILT_READ, 8'(FILTER_COUNT - 1), 4);
    run_frame(scd_pkg::CMD_FILT_WRITE, 8'(FILTER_COUNT - 1), 4);
    run_frame(scd_pkg::CMD_FILT_WRITE, 8'd0, 3);
    run_frame(scd_pkg::CMD_FILT_WRITE, 8'hFF, 2);
    run_frame(scd_pkg::CMD_FILT_READ, 8'd0, 4);
    run_frame(scd_pkg::CMD_FILT_READ, 8'(FILTER_COUNT - 1), 4);
    run_frame(scd_pkg::CMD_FILT_COMMIT, 8'hA5, 2);
    run_frame(scd_pkg::CMD_NODE_FILT, 8'h3C, 3);
    run_frame(8'h0F, 8'h00, 1);
    run_frame(8'h10, 8'h00, 1);
    run_frame(8'hFF, 8'h00, 1);
    // re-arm inside an open frame
    send_event(scd_pkg::EV_SEL_FALL, 8'h00, 4'h0, 8'h00);
    send_byte(scd_pkg::CMD_STATUS);
    run_frame(scd_pkg::CMD_UID, 8'h00, 1);
  endtask

  task automatic test_far_offsets();
    wait_drained();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    run_frame(scd_pkg::CMD_FILT_READ, 8'hFF, 3);
    run_frame(scd_pkg::CMD_FILT_WRITE, 8'hFF, 3);
    run_frame(scd_pkg::CMD_UID, 8'h00, FAR_FRAME_BYTES);
    wait_drained();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_off_req = 1'b1;
    src_gaps_on  = 1'b0;
    for (int i = 0; i < 6; i++) run_frame(scd_pkg::CMD_STATUS, 8'h00, 5);
    src_gaps_on = 1'b1;
    wait_drained();
    for (int i = 0; i < 10; i++) random_frame();
  endtask

  task automatic test_random();
    int start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       load_ident('1, '0);
        1:       load_ident('0, '1);
        default: load_ident({32'($urandom), 32'($urandom)}, 32'($urandom));
      endcase
      src_gaps_on    = (phase != 1);
      sink_stalls_on = (phase != 1);
      start = n_sent;
      while (n_sent - start < RANDOM_ITEMS / 4) random_frame();
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        sink_held <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        sink_held <= 1'b0;
        hold_off_req = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || sink_held) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall_left != 0) begin
      m_axis_tready   <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
      m_axis_tready   <= 1'b0;
      sink_stall_left <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, 32'h0);
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tuser !== want.valid)
          report_mismatch("reply_valid", m_axis_tuser, want.valid);
        if (m_axis_tdata[7:0] !== want.reply)
          report_mismatch("reply_byte", m_axis_tdata[7:0], want.reply);
        if (m_axis_tdata[11:8] !== want.act)
          report_mismatch("action", m_axis_tdata[11:8], want.act);
        if (m_axis_tdata[16:12] !== want.idx)
          report_mismatch("action_index", m_axis_tdata[16:12], want.idx);
        if (m_axis_tdata[24:17] !== want.val)
          report_mismatch("action_value", m_axis_tdata[24:17], want.val);
      end
    end
  end

  initial begin
    #20ms;
    $display("Timeout with %0d replies outstanding", expected_replies.size());
    $display("** spi_command_slave_decoder: FAILED **");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rx_load();
    test_ident_registers();
    test_commands();
    test_far_offsets();
    test_backpressure();
    test_random();
    wait_drained();
    $display("Covered %0d input transfers in %0d frames, %0d replies checked, %0d mismatches",
             n_sent, n_frames, n_checked, n_errors);
    $display("Side actions %0d (filter writes %0d), far offsets and output hold-off",
             n_actions, n_filt_writes);
    if (n_errors == 0) begin
      $display("** spi_command_slave_decoder: PASSED **");
    end else begin
      $display("** spi_command_slave_decoder: FAILED **");
    end
    $finish;
  end

endmodule
